### src/sitdt_pkg.sv
// Package for the scaled integer to decimal text unit.
// Sequencer states, character codes and shared types; no dependencies.
package sitdt_pkg;

    localparam int          MAX_SUFFIX = 4;
    localparam int          MAX_FRAC   = 9;
    localparam int          NUM_DIGITS = 10;
    localparam logic [7:0]  CH_ZERO    = 8'h30;
    localparam logic [7:0]  CH_MINUS   = 8'h2D;
    localparam logic [7:0]  CH_POINT   = 8'h2E;

    typedef logic [NUM_DIGITS-1:0][3:0] t_digits;

    typedef enum logic [2:0] {
        CFG_SCALE  = 3'd0,
        CFG_FRAC   = 3'd1,
        CFG_SFX    = 3'd2,
        CFG_SFXLEN = 3'd3,
        CFG_CAP    = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_MUL,
        ST_DIV2,
        ST_FIX,
        ST_CONV,
        ST_CHECK,
        ST_EMIT,
        ST_FAIL
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_conv_ctl;

endpackage

### src/sitdt_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add three).
// Depends on sitdt_pkg.
module sitdt_bcd_conv (
    input  logic               i_clk,
    input  sitdt_pkg::t_conv_ctl i_ctl,
    input  logic [31:0]        i_value,
    output sitdt_pkg::t_digits o_digits
);
    import sitdt_pkg::*;

    logic [31:0] r_bin;
    t_digits     r_bcd;
    t_digits     adj;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (i_ctl.step) begin
            // top digit never exceeds 4, so its msb drops out safely
            r_bcd <= {adj[NUM_DIGITS-1][2:0], adj[NUM_DIGITS-2:0], r_bin[31]};
            r_bin <= {r_bin[30:0], 1'b0};
        end
    end

    assign o_digits = r_bcd;
endmodule

### src/scaled_integer_to_decimal_text_unit.sv
// Top level of the scaled integer to decimal text unit.
// Depends on sitdt_pkg and sitdt_bcd_conv.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+-------------------------
//  request   | i_raw_value                            | i_start while !o_busy
//  result    | o_character, o_last, o_failed          | o_strobe, one cycle each
//  config    | i_cfg_idx, i_cfg_data                  | i_cfg_we, no wait
//
// A request runs a 32-step bit-serial divide for the whole part, then
// fraction_digits multiply-by-ten steps, a 64-step divide for the rounded
// fraction and a 32-step BCD conversion, then one character per cycle.
// Bad configuration goes from idle straight to the fail state.
// Reset (synchronous, active low) restores the register defaults and idles.
// The receiver cannot stall; results stream out one per cycle.
module scaled_integer_to_decimal_text_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic signed [31:0] i_raw_value,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic [7:0]  o_character,
    output logic        o_last,
    output logic        o_failed
);
    import sitdt_pkg::*;

    // configuration registers
    logic [31:0] r_scale;
    logic [3:0]  r_fdig;
    logic [31:0] r_sfx;
    logic [2:0]  r_sfxlen;
    logic [6:0]  r_cap;

    t_state      r_state, n_state;

    logic        r_neg;
    logic [63:0] r_dvd;
    logic [31:0] r_rem;
    logic [6:0]  r_cnt;
    logic [31:0] r_whole;
    logic [63:0] r_prod;
    logic [31:0] r_fs;
    logic [3:0]  r_nd;
    logic [4:0]  r_len;
    logic [4:0]  r_pos;

    logic        r_strobe;
    logic [7:0]  r_char;
    logic        r_last;
    logic        r_failed;

    t_conv_ctl   conv_ctl;
    t_digits     wd, fd;
    logic [31:0] conv_whole, conv_frac;

    logic        accept, cfg_bad;
    logic [31:0] mag;
    logic [32:0] dv_try;
    logic        dv_ge;
    logic [31:0] dv_rem_n;
    logic [63:0] dv_dvd_n;
    logic        carry;

    // length check and emission
    logic [3:0]  nd;
    logic [2:0]  slen;
    logic [4:0]  tlen;
    logic [4:0]  w_end, p_end, f_end, idx;
    logic [7:0]  ch;
    logic        is_last;

    assign accept  = i_start && (r_state == ST_IDLE);
    assign o_busy  = (r_state != ST_IDLE);
    assign cfg_bad = (r_scale == 32'd0) || (r_fdig > 4'(MAX_FRAC)) || (r_cap == 7'd0);
    assign mag     = i_raw_value[31] ? 32'(-i_raw_value) : i_raw_value;

    // one restoring divide step, shared by both divisions
    assign dv_try   = {r_rem, r_dvd[63]};
    assign dv_ge    = dv_try >= {1'b0, r_scale};
    assign dv_rem_n = dv_ge ? 32'(dv_try - {1'b0, r_scale}) : dv_try[31:0];
    assign dv_dvd_n = {r_dvd[62:0], dv_ge};

    // rounded fraction reaching a full unit carries into the whole part
    assign carry      = (r_dvd[31:0] == r_fs);
    assign conv_whole = carry ? r_whole + 32'd1 : r_whole;
    assign conv_frac  = carry ? 32'd0 : r_dvd[31:0];

    sitdt_bcd_conv u_whole_conv (
        .i_clk    (i_clk),
        .i_ctl    (conv_ctl),
        .i_value  (conv_whole),
        .o_digits (wd)
    );

    sitdt_bcd_conv u_frac_conv (
        .i_clk    (i_clk),
        .i_ctl    (conv_ctl),
        .i_value  (conv_frac),
        .o_digits (fd)
    );

    // count of whole digits and effective suffix length
    always_comb begin
        logic stop;
        logic [2:0] lim;
        nd = 4'd1;
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (wd[i] != 4'd0) nd = 4'(i + 1);
        end
        lim  = (r_sfxlen > 3'(MAX_SUFFIX)) ? 3'(MAX_SUFFIX) : r_sfxlen;
        slen = lim;
        stop = 1'b0;
        for (int i = 0; i < MAX_SUFFIX; i++) begin
            if (!stop && (3'(i) < lim) && (r_sfx[8*i +: 8] == 8'd0)) begin
                slen = 3'(i);
                stop = 1'b1;
            end
        end
        tlen = 5'(r_neg) + 5'(nd) + ((r_fdig != 4'd0) ? 5'(r_fdig) + 5'd1 : 5'd0)
             + 5'(slen);
    end

    // character at the current text position
    always_comb begin
        w_end   = 5'(r_neg) + 5'(r_nd);
        p_end   = w_end + ((r_fdig != 4'd0) ? 5'd1 : 5'd0);
        f_end   = p_end + 5'(r_fdig);
        idx     = 5'd0;
        is_last = (r_pos == r_len - 5'd1);
        if (r_pos < 5'(r_neg)) begin
            ch = CH_MINUS;
        end else if (r_pos < w_end) begin
            idx = w_end - 5'd1 - r_pos;
            ch  = CH_ZERO | {4'd0, wd[idx[3:0]]};
        end else if (r_pos < p_end) begin
            ch = CH_POINT;
        end else if (r_pos < f_end) begin
            idx = f_end - 5'd1 - r_pos;
            ch  = CH_ZERO | {4'd0, fd[idx[3:0]]};
        end else begin
            idx = r_pos - f_end;
            ch  = r_sfx[8*idx[1:0] +: 8];
        end
    end

    // next state and converter control
    always_comb begin
        n_state       = r_state;
        conv_ctl.load = 1'b0;
        conv_ctl.step = 1'b0;
        case (r_state)
            ST_IDLE:  if (accept) n_state = cfg_bad ? ST_FAIL : ST_DIV1;
            ST_DIV1:  if (r_cnt == 7'd1) n_state = ST_MUL;
            ST_MUL:   if (r_cnt == 7'd0) n_state = ST_DIV2;
            ST_DIV2:  if (r_cnt == 7'd1) n_state = ST_FIX;
            ST_FIX: begin
                conv_ctl.load = 1'b1;
                n_state       = ST_CONV;
            end
            ST_CONV: begin
                conv_ctl.step = 1'b1;
                if (r_cnt == 7'd1) n_state = ST_CHECK;
            end
            ST_CHECK: n_state = ({2'd0, tlen} >= r_cap) ? ST_FAIL : ST_EMIT;
            ST_EMIT:  if (is_last) n_state = ST_IDLE;
            ST_FAIL:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 32'd1;
            r_fdig   <= 4'd0;
            r_sfx    <= 32'd0;
            r_sfxlen <= 3'd0;
            r_cap    <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE:  r_scale  <= i_cfg_data;
                CFG_FRAC:   r_fdig   <= i_cfg_data[3:0];
                CFG_SFX:    r_sfx    <= i_cfg_data;
                CFG_SFXLEN: r_sfxlen <= i_cfg_data[2:0];
                CFG_CAP:    r_cap    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_neg <= i_raw_value[31];
                    r_dvd <= {mag, 32'd0};
                    r_rem <= 32'd0;
                    r_cnt <= 7'd32;
                end
            end
            ST_DIV1: begin
                r_dvd <= dv_dvd_n;
                r_rem <= dv_rem_n;
                if (r_cnt == 7'd1) begin
                    r_whole <= dv_dvd_n[31:0];
                    r_prod  <= {32'd0, dv_rem_n};
                    r_fs    <= 32'd1;
                    r_cnt   <= {3'd0, r_fdig};
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end
            ST_MUL: begin
                if (r_cnt == 7'd0) begin
                    r_dvd <= r_prod + {33'd0, r_scale[31:1]};
                    r_rem <= 32'd0;
                    r_cnt <= 7'd64;
                end else begin
                    r_prod <= {r_prod[60:0], 3'd0} + {r_prod[62:0], 1'b0};
                    r_fs   <= {r_fs[28:0], 3'd0} + {r_fs[30:0], 1'b0};
                    r_cnt  <= r_cnt - 7'd1;
                end
            end
            ST_DIV2: begin
                r_dvd <= dv_dvd_n;
                r_rem <= dv_rem_n;
                r_cnt <= r_cnt - 7'd1;
            end
            ST_FIX:   r_cnt <= 7'd32;
            ST_CONV:  r_cnt <= r_cnt - 7'd1;
            ST_CHECK: begin
                r_nd   <= nd;
                r_len  <= tlen;
                r_pos  <= 5'd0;
            end
            ST_EMIT:  r_pos <= r_pos + 5'd1;
            default: ;
        endcase
    end

    // result register: one strobe per character or one failure
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_EMIT) || (r_state == ST_FAIL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FAIL) begin
            r_char   <= 8'd0;
            r_last   <= 1'b1;
            r_failed <= 1'b1;
        end else begin
            r_char   <= ch;
            r_last   <= is_last;
            r_failed <= 1'b0;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_failed    = r_failed;
endmodule
